[hw/rtl/fwom_pkg.sv]
// shared constants, register codes and the sine table builder for the oscillator mixer
package fwom_pkg;

   localparam int PHASE_BITS_DEFAULT      = 32;
   localparam int SINE_TABLE_BITS_DEFAULT = 10;

   localparam int STEP_W   = 32;
   localparam int AMP_W    = 15;
   localparam int SAMPLE_W = 16;
   localparam int CSR_AW   = 4;
   localparam int CSR_DW   = 32;

   // register codes, taken from paddr[3:2]
   localparam logic [1:0] CSR_AMP_SINE     = 2'd0;
   localparam logic [1:0] CSR_AMP_SAW      = 2'd1;
   localparam logic [1:0] CSR_AMP_TRIANGLE = 2'd2;
   localparam logic [1:0] CSR_AMP_SQUARE   = 2'd3;

   localparam int SAMPLE_MAX = 32767;
   localparam int SAMPLE_MIN = -32768;

   // pi/2 in q30
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   // taylor series divisors (2n)(2n+1)
   localparam logic [63:0] TaylorDiv [1:6] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156};

   typedef logic [AMP_W-1:0] amp_type;

   // q0.15 magnitude of sin(r / 2^(tbits-2) * pi/2), evaluated at elaboration only
   function automatic amp_type quarter_sine(input int unsigned r, input int unsigned tbits);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] mag;
      logic [63:0] t;
      longint      acc;
      x   = (64'(r) * HALF_PI_Q30) >> (tbits - 2);
      x2  = (x * x) >> 30;
      mag = x;
      acc = longint'(x);
      for (int n = 1; n <= 6; n++) begin
         mag = ((mag * x2) >> 30) / TaylorDiv[n];
         if (n[0]) begin
            acc = acc - longint'(mag);
         end else begin
            acc = acc + longint'(mag);
         end
      end
      if (acc < 0) begin
         acc = 0;
      end
      t = (64'(acc) + 64'd16384) >> 15;
      if (t > 64'd32767) begin
         t = 64'd32767;
      end
      return t[AMP_W-1:0];
   endfunction

endpackage

[hw/rtl/four_waveform_oscillator_mix_unit.sv]
// four-waveform dds oscillator with saturating mixer and apb amplitude registers
// One sample is produced per accepted transaction, and a new transaction can be
// accepted every cycle while the result is not stalled. There are two register
// stages: the input register (phase accumulator with restart applied) and the
// result register. The logic between them does the quarter-wave sine table read,
// the sawtooth and triangle magnitudes, the three amplitude multiplies, the sum and
// the saturation to signed 16 bits. rsp_valid rises when the transaction enters the
// result register. While the result is stalled, one transaction can wait in the
// input register and one in the result register before req_stall rises. The
// amplitude registers are at byte addresses 0, 4, 8 and 12 (sine, sawtooth,
// triangle, square) and must only be written while the block is idle.
module four_waveform_oscillator_mix_unit #(
   parameter int PHASE_BITS      = fwom_pkg::PHASE_BITS_DEFAULT,
   parameter int SINE_TABLE_BITS = fwom_pkg::SINE_TABLE_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_restart,
   input  logic [fwom_pkg::STEP_W-1:0]         req_phase_step,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [fwom_pkg::SAMPLE_W-1:0] rsp_sample,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [fwom_pkg::CSR_AW-1:0]         csr_paddr,
   input  logic [fwom_pkg::CSR_DW-1:0]         csr_pwdata,
   output logic [fwom_pkg::CSR_DW-1:0]         csr_prdata,
   output logic                                csr_pready
);

   localparam int AW          = fwom_pkg::AMP_W;
   localparam int QUARTER_LEN = 1 << (SINE_TABLE_BITS - 2);
   localparam int QIDX_W      = SINE_TABLE_BITS - 1;
   localparam int SUM_W       = AW + 3;
   localparam logic [PHASE_BITS+1:0] PHASE_ONE = (PHASE_BITS + 2)'(1) << PHASE_BITS;

   // ---------------- amplitude registers ----------------
   fwom_pkg::amp_type amp_sine_ff, amp_sine_in;
   fwom_pkg::amp_type amp_saw_ff, amp_saw_in;
   fwom_pkg::amp_type amp_tri_ff, amp_tri_in;
   fwom_pkg::amp_type amp_sqr_ff, amp_sqr_in;
   logic              csr_wr;
   logic [1:0]        csr_index;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[3:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      amp_sine_in = amp_sine_ff;
      amp_saw_in  = amp_saw_ff;
      amp_tri_in  = amp_tri_ff;
      amp_sqr_in  = amp_sqr_ff;
      if (csr_wr) begin
         unique case (csr_index)
            fwom_pkg::CSR_AMP_SINE:     amp_sine_in = csr_pwdata[AW-1:0];
            fwom_pkg::CSR_AMP_SAW:      amp_saw_in  = csr_pwdata[AW-1:0];
            fwom_pkg::CSR_AMP_TRIANGLE: amp_tri_in  = csr_pwdata[AW-1:0];
            fwom_pkg::CSR_AMP_SQUARE:   amp_sqr_in  = csr_pwdata[AW-1:0];
            default:                    amp_sine_in = amp_sine_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         fwom_pkg::CSR_AMP_SINE:     csr_prdata = fwom_pkg::CSR_DW'(amp_sine_ff);
         fwom_pkg::CSR_AMP_SAW:      csr_prdata = fwom_pkg::CSR_DW'(amp_saw_ff);
         fwom_pkg::CSR_AMP_TRIANGLE: csr_prdata = fwom_pkg::CSR_DW'(amp_tri_ff);
         fwom_pkg::CSR_AMP_SQUARE:   csr_prdata = fwom_pkg::CSR_DW'(amp_sqr_ff);
         default:                    csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         amp_sine_ff <= '0;
         amp_saw_ff  <= '0;
         amp_tri_ff  <= '0;
         amp_sqr_ff  <= '0;
      end else begin
         amp_sine_ff <= amp_sine_in;
         amp_saw_ff  <= amp_saw_in;
         amp_tri_ff  <= amp_tri_in;
         amp_sqr_ff  <= amp_sqr_in;
      end
   end

   // ---------------- flow control ----------------
   logic a_valid_ff, a_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_ready, a_ready, req_fire;

   assign rsp_ready = !rsp_valid_ff || !rsp_stall;
   assign a_ready   = !a_valid_ff || rsp_ready;
   assign req_stall = !a_ready;
   assign req_fire  = req_valid && a_ready;

   assign a_valid_in   = a_ready ? req_valid : a_valid_ff;
   assign rsp_valid_in = rsp_ready ? a_valid_ff : rsp_valid_ff;

   // ---------------- phase accumulator ----------------
   logic [PHASE_BITS-1:0] phase_acc_ff, phase_acc_in;
   logic [PHASE_BITS-1:0] phase_use;
   logic [PHASE_BITS-1:0] step_ext;
   logic [PHASE_BITS-1:0] a_phase_ff, a_phase_in;

   if (PHASE_BITS > fwom_pkg::STEP_W) begin : g_step_wide
      assign step_ext = {{(PHASE_BITS - fwom_pkg::STEP_W){1'b0}}, req_phase_step};
   end else if (PHASE_BITS == fwom_pkg::STEP_W) begin : g_step_same
      assign step_ext = req_phase_step;
   end else begin : g_step_narrow
      assign step_ext = req_phase_step[PHASE_BITS-1:0];
   end

   // restart zeroes the phase before this sample is formed
   assign phase_use    = req_restart ? '0 : phase_acc_ff;
   assign phase_acc_in = req_fire ? PHASE_BITS'(phase_use + step_ext) : phase_acc_ff;
   assign a_phase_in   = req_fire ? phase_use : a_phase_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_acc_ff <= '0;
         a_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_acc_ff <= phase_acc_in;
         a_valid_ff   <= a_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // ---------------- waveform terms ----------------
   fwom_pkg::amp_type quarter_rom [QUARTER_LEN+1];

   for (genvar gi = 0; gi <= QUARTER_LEN; gi++) begin : g_rom
      localparam fwom_pkg::amp_type ROM_VAL = fwom_pkg::quarter_sine(gi, SINE_TABLE_BITS);
      assign quarter_rom[gi] = ROM_VAL;
   end

   logic [1:0]                  quad;
   logic [SINE_TABLE_BITS-3:0]  roff;
   logic [QIDX_W-1:0]           rom_idx;
   logic [PHASE_BITS-1:0]       saw_mag;
   logic [PHASE_BITS+1:0]       v4;
   logic [PHASE_BITS:0]         tri_mag;
   logic                        tri_neg;
   fwom_pkg::amp_type           sine_mag;

   always_comb begin
      quad = a_phase_ff[PHASE_BITS-1 -: 2];
      roff = a_phase_ff[PHASE_BITS-3 -: (SINE_TABLE_BITS - 2)];
      // odd quadrants read the table mirrored
      if (quad[0]) begin
         rom_idx = QIDX_W'(QUARTER_LEN) - {1'b0, roff};
      end else begin
         rom_idx = {1'b0, roff};
      end
      // distance from phase zero, the sawtooth magnitude
      if (a_phase_ff[PHASE_BITS-1]) begin
         saw_mag = PHASE_BITS'(~a_phase_ff + 1'b1);
      end else begin
         saw_mag = a_phase_ff;
      end
      v4 = {saw_mag, 2'b00};
      if (v4 >= PHASE_ONE) begin
         tri_mag = (PHASE_BITS + 1)'(v4 - PHASE_ONE);
         tri_neg = 1'b0;
      end else begin
         tri_mag = (PHASE_BITS + 1)'(PHASE_ONE - v4);
         tri_neg = 1'b1;
      end
   end

   assign sine_mag = quarter_rom[rom_idx];

   // ---------------- mix ----------------
   logic [2*AW-1:0]          sine_prod;
   logic [PHASE_BITS+AW-1:0] saw_prod;
   logic [PHASE_BITS+AW:0]   tri_prod;
   logic signed [SUM_W-1:0]  sine_term, saw_term, tri_term, sqr_term, mix_sum;
   logic signed [fwom_pkg::SAMPLE_W-1:0] mix_sat;
   logic signed [fwom_pkg::SAMPLE_W-1:0] rsp_sample_ff, rsp_sample_in;

   assign sine_prod = (2*AW)'(amp_sine_ff) * (2*AW)'(sine_mag);
   assign saw_prod  = (PHASE_BITS + AW)'(amp_saw_ff) * (PHASE_BITS + AW)'(saw_mag);
   assign tri_prod  = (PHASE_BITS + AW + 1)'(amp_tri_ff) * (PHASE_BITS + AW + 1)'(tri_mag);

   always_comb begin
      logic signed [SUM_W-1:0] sine_abs;
      logic signed [SUM_W-1:0] saw_abs;
      logic signed [SUM_W-1:0] tri_abs;
      logic signed [SUM_W-1:0] sqr_abs;
      sine_abs  = {3'b000, sine_prod[2*AW-1:AW]};
      saw_abs   = {2'b00, saw_prod[PHASE_BITS+AW-1:PHASE_BITS-1]};
      tri_abs   = {2'b00, tri_prod[PHASE_BITS+AW:PHASE_BITS]};
      sqr_abs   = {3'b000, amp_sqr_ff};
      sine_term = quad[1] ? -sine_abs : sine_abs;
      saw_term  = a_phase_ff[PHASE_BITS-1] ? -saw_abs : saw_abs;
      tri_term  = tri_neg ? -tri_abs : tri_abs;
      // square follows the sign of the table sine, zero where the sine is zero
      if (sine_mag == '0) begin
         sqr_term = '0;
      end else begin
         sqr_term = quad[1] ? -sqr_abs : sqr_abs;
      end
      mix_sum = sine_term + saw_term + tri_term + sqr_term;
      if (mix_sum > fwom_pkg::SAMPLE_MAX) begin
         mix_sat = fwom_pkg::SAMPLE_W'(fwom_pkg::SAMPLE_MAX);
      end else if (mix_sum < fwom_pkg::SAMPLE_MIN) begin
         mix_sat = fwom_pkg::SAMPLE_W'(fwom_pkg::SAMPLE_MIN);
      end else begin
         mix_sat = mix_sum[fwom_pkg::SAMPLE_W-1:0];
      end
   end

   assign rsp_sample_in = (rsp_ready && a_valid_ff) ? mix_sat : rsp_sample_ff;

   always_ff @(posedge clock) begin
      a_phase_ff    <= a_phase_in;
      rsp_sample_ff <= rsp_sample_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_sample = rsp_sample_ff;

   // ---------------- assertions ----------------
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (a_valid_ff && rsp_valid_ff))
      else $error("input stalled while a pipeline stage is empty");

   a_restart_zero_phase: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_restart) |=> (a_phase_ff == '0))
      else $error("restart transaction did not start at phase zero");

   a_result_from_input_stage: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(a_valid_ff))
      else $error("result appeared without a transaction in the input register");

endmodule
